@@ rtl/pdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared types and constants for the pinhole depth/pose reprojection warp.
// ----------------------------------------------------------------------------
package pdr_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FOCAL_X     = 3'd0,
    CFG_FOCAL_Y     = 3'd1,
    CFG_CENTER_X    = 3'd2,
    CFG_CENTER_Y    = 3'd3,
    CFG_ROT_ROW_X   = 3'd4,
    CFG_ROT_ROW_Y   = 3'd5,
    CFG_ROT_ROW_Z   = 3'd6,
    CFG_TRANSLATION = 3'd7
  } pdr_cfg_e;

  // register reset values
  localparam logic [15:0] FOCAL_X_RST  = 16'd8192;
  localparam logic [15:0] FOCAL_Y_RST  = 16'd8192;
  localparam logic [15:0] CENTER_X_RST = 16'd5120;
  localparam logic [15:0] CENTER_Y_RST = 16'd3840;
  localparam logic [47:0] ROT_X_RST    = 48'h4000_0000_0000;
  localparam logic [47:0] ROT_Y_RST    = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_Z_RST    = 48'h0000_0000_4000;

  // back-projection divider: |diff|*d*256 over focal length
  localparam int unsigned BP_NUM_W = 40;
  localparam int unsigned BP_DEN_W = 16;
  // projection divider: f*|X| over Z, quotient clamped at 2^20
  localparam int unsigned PJ_NUM_W = 75;
  localparam int unsigned PJ_DEN_W = 59;
  localparam int unsigned PJ_QUO_W = 20;
  localparam int unsigned DATA_W   = 60;

  // flags that travel through the column projection divider
  typedef struct packed {
    logic neg;
    logic over;
    logic zpos;
    logic bad_f;
  } pdr_side_u_t;

  // flags that travel through the row projection divider
  typedef struct packed {
    logic neg;
    logic over;
  } pdr_side_v_t;

endpackage

@@ rtl/pdr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees num >> QW is below den. Side data rides along with each item.
// ----------------------------------------------------------------------------
module pdr_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 40,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [QW+1];
  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] bits_q [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  // stage 0 is the unregistered input
  assign v_q[0]    = valid_i;
  assign rem_q[0]  = DW'(num_i >> QW);
  assign bits_q[0] = num_i[QW-1:0];
  assign quo_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_d;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      trial = {rem_q[s-1], bits_q[s-1][QW-1]};
      ge    = trial >= {1'b0, den_q[s-1]};
      rem_d = ge ? DW'(trial - {1'b0, den_q[s-1]}) : trial[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        bits_q[s] <= bits_q[s-1] << 1;
        quo_q[s]  <= {quo_q[s-1][QW-2:0], ge};
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quo_o   = quo_q[QW];
  assign side_o  = side_q[QW];

endmodule

@@ rtl/pinhole_depth_pose_reprojection.sv @@
`timescale 1ns / 1ps
// Pipeline depth from input transfer to result is set by the two bit-serial
//   divider pipelines (40 stages back-projection, 20 stages projection).
// Throughput: one pixel per cycle; a stalled output freezes the whole pipe.
// Reset: valid bits clear, configuration returns to the default intrinsics
//   and identity pose; payload registers are not reset.
// ----------------------------------------------------------------------------
// pinhole_depth_pose_reprojection
// Back-projects a pixel with depth, applies R*p+t, projects into the target
// view with saturation and a validity flag.
// ----------------------------------------------------------------------------
module pinhole_depth_pose_reprojection (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pixel_u_i,
  input  logic [15:0] pixel_v_i,
  input  logic [15:0] point_depth_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] target_u_o,
  output logic signed [15:0] target_v_o,
  output logic        valid_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [59:0] cfg_data_i
);
  import pdr_pkg::*;

  logic en;

  // configuration registers
  logic [15:0] fx_q, fy_q, cx_q, cy_q;
  logic [47:0] rot_q [3];
  logic [59:0] trans_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q     <= FOCAL_X_RST;
      fy_q     <= FOCAL_Y_RST;
      cx_q     <= CENTER_X_RST;
      cy_q     <= CENTER_Y_RST;
      rot_q[0] <= ROT_X_RST;
      rot_q[1] <= ROT_Y_RST;
      rot_q[2] <= ROT_Z_RST;
      trans_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (pdr_cfg_e'(cfg_index_i))
        CFG_FOCAL_X:     fx_q     <= cfg_data_i[15:0];
        CFG_FOCAL_Y:     fy_q     <= cfg_data_i[15:0];
        CFG_CENTER_X:    cx_q     <= cfg_data_i[15:0];
        CFG_CENTER_Y:    cy_q     <= cfg_data_i[15:0];
        CFG_ROT_ROW_X:   rot_q[0] <= cfg_data_i[47:0];
        CFG_ROT_ROW_Y:   rot_q[1] <= cfg_data_i[47:0];
        CFG_ROT_ROW_Z:   rot_q[2] <= cfg_data_i[47:0];
        CFG_TRANSLATION: trans_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global pipeline advance
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage 1: |pixel - center| * depth * 256
  logic [16:0] diff_u, diff_v, abs_u, abs_v;
  logic        s1_v_q, s1_su_q, s1_sv_q;
  logic [BP_NUM_W-1:0] s1_nu_q, s1_nv_q;
  logic [15:0] s1_d_q;

  always_comb begin
    diff_u = {1'b0, pixel_u_i} - {1'b0, cx_q};
    diff_v = {1'b0, pixel_v_i} - {1'b0, cy_q};
    abs_u  = diff_u[16] ? 17'(-diff_u) : diff_u;
    abs_v  = diff_v[16] ? 17'(-diff_v) : diff_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_su_q <= diff_u[16];
      s1_sv_q <= diff_v[16];
      s1_nu_q <= {32'(abs_u[15:0]) * 32'(point_depth_i), 8'd0};
      s1_nv_q <= {32'(abs_v[15:0]) * 32'(point_depth_i), 8'd0};
      s1_d_q  <= point_depth_i;
    end
  end

  // back-projection dividers
  logic                d1_vx, d1_vy, d1_sx;
  logic [BP_NUM_W-1:0] d1_qx, d1_qy;
  logic [16:0]         d1_sy;

  pdr_div #(.NW(BP_NUM_W), .DW(BP_DEN_W), .QW(BP_NUM_W), .SW(1)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s1_v_q), .num_i(s1_nu_q), .den_i(fx_q),
    .side_i(s1_su_q), .valid_o(d1_vx), .quo_o(d1_qx), .side_o(d1_sx)
  );

  pdr_div #(.NW(BP_NUM_W), .DW(BP_DEN_W), .QW(BP_NUM_W), .SW(17)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s1_v_q), .num_i(s1_nv_q), .den_i(fy_q),
    .side_i({s1_sv_q, s1_d_q}), .valid_o(d1_vy), .quo_o(d1_qy), .side_o(d1_sy)
  );

  // ---------------- stage 2: signed camera point
  logic               s2_v_q, s2_badf_q;
  logic signed [40:0] s2_p_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= d1_vx;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_badf_q <= (fx_q == '0) || (fy_q == '0);
      if (fx_q == '0) s2_p_q[0] <= '0;
      else s2_p_q[0] <= d1_sx ? -$signed({1'b0, d1_qx}) : $signed({1'b0, d1_qx});
      if (fy_q == '0) s2_p_q[1] <= '0;
      else s2_p_q[1] <= d1_sy[16] ? -$signed({1'b0, d1_qy}) : $signed({1'b0, d1_qy});
      s2_p_q[2] <= $signed({17'd0, d1_sy[15:0], 8'd0});
    end
  end

  // ---------------- stage 3: rotation products
  logic               s3_v_q, s3_badf_q;
  logic signed [56:0] s3_m_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_badf_q <= s2_badf_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s3_m_q[i][j] <= $signed(rot_q[i][47-16*j -: 16]) * s2_p_q[j];
        end
      end
    end
  end

  // ---------------- stage 4: sums plus translation
  logic               s4_v_q, s4_badf_q;
  logic signed [59:0] s4_b_q [3];
  logic signed [59:0] b_d [3];
  logic signed [59:0] t_ext [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_ext[i] = {{18{trans_q[59-20*i]}}, trans_q[59-20*i -: 20], 22'd0};
      b_d[i]   = 60'(s3_m_q[i][0]) + 60'(s3_m_q[i][1]) + 60'(s3_m_q[i][2]) + t_ext[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_badf_q <= s3_badf_q;
      s4_b_q    <= b_d;
    end
  end

  // ---------------- stage 5: magnitudes, depth sign
  logic                s5_v_q, s5_badf_q, s5_nu_q, s5_nv_q, s5_zpos_q;
  logic [PJ_DEN_W-1:0] s5_mu_q, s5_mv_q, s5_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en) s5_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_badf_q <= s4_badf_q;
      s5_nu_q   <= s4_b_q[0][59];
      s5_nv_q   <= s4_b_q[1][59];
      s5_mu_q   <= s4_b_q[0][59] ? PJ_DEN_W'(-s4_b_q[0]) : s4_b_q[0][PJ_DEN_W-1:0];
      s5_mv_q   <= s4_b_q[1][59] ? PJ_DEN_W'(-s4_b_q[1]) : s4_b_q[1][PJ_DEN_W-1:0];
      s5_zpos_q <= !s4_b_q[2][59] && (s4_b_q[2] != '0);
      s5_den_q  <= s4_b_q[2][PJ_DEN_W-1:0];
    end
  end

  // ---------------- stage 6: focal times magnitude
  logic                s6_v_q, s6_badf_q, s6_nu_q, s6_nv_q, s6_zpos_q;
  logic [PJ_NUM_W-1:0] s6_pu_q, s6_pv_q;
  logic [PJ_DEN_W-1:0] s6_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_v_q <= 1'b0;
    else if (en) s6_v_q <= s5_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_badf_q <= s5_badf_q;
      s6_nu_q   <= s5_nu_q;
      s6_nv_q   <= s5_nv_q;
      s6_zpos_q <= s5_zpos_q;
      s6_pu_q   <= s5_mu_q * fx_q;
      s6_pv_q   <= s5_mv_q * fy_q;
      // a point behind the camera still needs a legal divisor
      s6_den_q  <= s5_zpos_q ? s5_den_q : PJ_DEN_W'(1);
    end
  end

  // ---------------- stage 7: quotient overflow check
  logic                s7_v_q;
  pdr_side_u_t         s7_su_q;
  pdr_side_v_t         s7_sv_q;
  logic [PJ_NUM_W-1:0] s7_pu_q, s7_pv_q;
  logic [PJ_DEN_W-1:0] s7_den_q;
  logic [PJ_DEN_W+PJ_QUO_W-1:0] den_sh;
  logic                over_u, over_v;

  always_comb begin
    den_sh = {s6_den_q, PJ_QUO_W'(0)};
    over_u = (PJ_DEN_W+PJ_QUO_W)'(s6_pu_q) >= den_sh;
    over_v = (PJ_DEN_W+PJ_QUO_W)'(s6_pv_q) >= den_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_v_q <= 1'b0;
    else if (en) s7_v_q <= s6_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_su_q  <= '{neg: s6_nu_q, over: over_u, zpos: s6_zpos_q, bad_f: s6_badf_q};
      s7_sv_q  <= '{neg: s6_nv_q, over: over_v};
      s7_pu_q  <= over_u ? '0 : s6_pu_q;
      s7_pv_q  <= over_v ? '0 : s6_pv_q;
      s7_den_q <= s6_den_q;
    end
  end

  // projection dividers
  logic                d2_vu, d2_vv;
  logic [PJ_QUO_W-1:0] d2_qu, d2_qv;
  pdr_side_u_t         d2_su;
  pdr_side_v_t         d2_sv;

  pdr_div #(.NW(PJ_NUM_W), .DW(PJ_DEN_W), .QW(PJ_QUO_W), .SW($bits(pdr_side_u_t)))
  u_div_u (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s7_v_q), .num_i(s7_pu_q), .den_i(s7_den_q),
    .side_i(s7_su_q), .valid_o(d2_vu), .quo_o(d2_qu), .side_o(d2_su)
  );

  pdr_div #(.NW(PJ_NUM_W), .DW(PJ_DEN_W), .QW(PJ_QUO_W), .SW($bits(pdr_side_v_t)))
  u_div_v (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s7_v_q), .num_i(s7_pv_q), .den_i(s7_den_q),
    .side_i(s7_sv_q), .valid_o(d2_vv), .quo_o(d2_qv), .side_o(d2_sv)
  );

  // ---------------- stage 8: sign, center offset, saturation (output register)
  logic [PJ_QUO_W:0]  qu, qv;
  logic signed [22:0] ru, rv;
  logic               sat_u_hi, sat_u_lo, sat_v_hi, sat_v_lo;
  logic signed [15:0] tu_d, tv_d;
  logic               res_d;
  logic signed [15:0] tu_q, tv_q;
  logic               res_q, zpos_q;

  always_comb begin
    qu = d2_su.over ? {1'b1, PJ_QUO_W'(0)} : {1'b0, d2_qu};
    qv = d2_sv.over ? {1'b1, PJ_QUO_W'(0)} : {1'b0, d2_qv};
    ru = (d2_su.neg ? -$signed({2'b0, qu}) : $signed({2'b0, qu}))
         + $signed({7'd0, cx_q});
    rv = (d2_sv.neg ? -$signed({2'b0, qv}) : $signed({2'b0, qv}))
         + $signed({7'd0, cy_q});
    sat_u_hi = ru > 23'sd32767;
    sat_u_lo = ru < -23'sd32768;
    sat_v_hi = rv > 23'sd32767;
    sat_v_lo = rv < -23'sd32768;
    tu_d = sat_u_hi ? 16'sh7fff : (sat_u_lo ? 16'sh8000 : ru[15:0]);
    tv_d = sat_v_hi ? 16'sh7fff : (sat_v_lo ? 16'sh8000 : rv[15:0]);
    res_d = !(d2_su.bad_f || sat_u_hi || sat_u_lo || sat_v_hi || sat_v_lo);
    if (!d2_su.zpos) begin
      tu_d  = '0;
      tv_d  = '0;
      res_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= d2_vu;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tu_q   <= tu_d;
      tv_q   <= tv_d;
      res_q  <= res_d;
      zpos_q <= d2_su.zpos;
    end
  end

  assign out_valid_o = out_valid_q;
  assign target_u_o  = tu_q;
  assign target_v_o  = tv_q;
  assign valid_res_o = res_q;

  // paired dividers stay in lock step
  a_bp_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d1_vx == d1_vy) else $error("back-projection dividers out of step");

  a_pj_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vu == d2_vv) else $error("projection dividers out of step");

  // point behind the camera yields zero, invalid result
  a_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !zpos_q) |-> (tu_q == '0 && tv_q == '0 && !res_q))
    else $error("behind-camera result not cleared");

  // projection divisor never zero
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s7_v_q |-> (s7_den_q != '0)) else $error("zero projection divisor");

endmodule
